>>> rtl/rgb_led_matrix_scan_pwm_assert.svh
`ifndef RGB_LED_MATRIX_SCAN_PWM_ASSERT_SVH
`define RGB_LED_MATRIX_SCAN_PWM_ASSERT_SVH

// same-cycle implication
`define RGBLED_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb_led_matrix_scan_pwm: check failed");

// next-cycle implication
`define RGBLED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb_led_matrix_scan_pwm: check failed");

// delayed implication
`define RGBLED_ASSERT_LATER2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("rgb_led_matrix_scan_pwm: check failed");

`endif

>>> rtl/rgbled_pkg.sv
package rgbled_pkg;

   localparam int NUM_COLUMNS_DEF = 8;
   localparam int COLOR_BITS_DEF  = 4;
   localparam int NUM_ROWS        = 8;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   typedef struct packed {
      logic       func;
      logic [2:0] pixel_column;
      logic [2:0] pixel_row;
      logic [3:0] red_level;
      logic [3:0] green_level;
      logic [3:0] blue_level;
      logic       bright_flag;
      logic [7:0] status_byte_in;
   } req_type;

   typedef struct packed {
      logic [2:0]          active_column;
      logic [7:0]          status_byte_out;
      logic [NUM_ROWS-1:0] red_rows;
      logic [NUM_ROWS-1:0] green_rows;
      logic [NUM_ROWS-1:0] blue_rows;
   } rsp_type;

endpackage

>>> rtl/rgbled_ram.sv
module rgbled_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read of the entry being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rgb_led_matrix_scan_pwm.sv
// A refresh tick's result passes through the stage-1 registers and then the registered output.
// Throughput: one item per cycle; each item makes one pass through the
// column-word memory (read when the item is accepted, merge/write back in stage 1).
// A pending result blocks new items only while the output is stalled.
// Reset (synchronous) clears counters, pipeline and per-column valid bits; the
// frame store reads as dark at once, with no clearing pass.
module rgb_led_matrix_scan_pwm #(
   parameter int NUM_COLUMNS = rgbled_pkg::NUM_COLUMNS_DEF,
   parameter int COLOR_BITS  = rgbled_pkg::COLOR_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rgbled_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rgbled_pkg::rsp_type rsp_payload
);

   import rgbled_pkg::*;

   localparam int COL_W   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int ENTRY_W = 3 * COLOR_BITS + 1;
   localparam int WORD_W  = NUM_ROWS * ENTRY_W;
   localparam logic [COL_W-1:0]      LAST_COL   = COL_W'(NUM_COLUMNS - 1);
   localparam logic [COLOR_BITS-1:0] LAST_CYCLE = '1;

   logic [COL_W-1:0]       col_ff, col_in;
   logic [COLOR_BITS-1:0]  pwm_ff, pwm_in;
   logic                   even_ff, even_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_tick_ff, s1_tick_in;
   logic                   s1_we_ff, s1_we_in;
   logic [COL_W-1:0]       s1_addr_ff, s1_addr_in;
   logic [2:0]             s1_row_ff, s1_row_in;
   logic [ENTRY_W-1:0]     s1_entry_ff, s1_entry_in;
   logic [7:0]             s1_status_ff, s1_status_in;
   logic [COLOR_BITS-1:0]  s1_pwm_ff, s1_pwm_in;
   logic                   s1_even_ff, s1_even_in;

   logic [NUM_COLUMNS-1:0] col_valid_ff, col_valid_in;
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [COL_W-1:0]       fwd_addr_ff, fwd_addr_in;
   logic [WORD_W-1:0]      fwd_word_ff, fwd_word_in;

   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;

   logic                   s1_stall, accept, is_tick, in_range, s1_write, fwd_hit;
   logic [COL_W+2:0]       pcol_x, col_x;
   logic [COLOR_BITS+3:0]  red_x, green_x, blue_x;
   logic [COL_W-1:0]       rd_addr;
   logic [WORD_W-1:0]      rd_data, cur_word, merged;
   logic [ENTRY_W-1:0]     entry;
   logic [NUM_ROWS-1:0]    red_rows, green_rows, blue_rows;
   logic                   lit;

   rgbled_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_COLUMNS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_addr_ff),
      .wr_data (merged),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign s1_stall  = s1_valid_ff && s1_tick_ff && out_valid_ff && rsp_stall;
   assign req_stall = s1_stall;
   assign accept    = req_valid && !s1_stall;
   assign is_tick   = req_payload.func == FUNC_TICK;
   assign pcol_x    = (COL_W + 3)'(req_payload.pixel_column);
   assign in_range  = pcol_x < (COL_W + 3)'(NUM_COLUMNS);
   assign red_x     = (COLOR_BITS + 4)'(req_payload.red_level);
   assign green_x   = (COLOR_BITS + 4)'(req_payload.green_level);
   assign blue_x    = (COLOR_BITS + 4)'(req_payload.blue_level);
   assign s1_write  = s1_valid_ff && !s1_tick_ff && s1_we_ff;
   assign fwd_hit   = fwd_valid_ff && (fwd_addr_ff == s1_addr_ff);
   assign col_x     = (COL_W + 3)'(s1_addr_ff);

   // column and PWM counters advance at the tick transfer
   always_comb begin
      col_in  = col_ff;
      pwm_in  = pwm_ff;
      even_in = even_ff;
      if (accept && is_tick) begin
         if (col_ff == LAST_COL) begin
            col_in = '0;
            if (pwm_ff == LAST_CYCLE) begin
               pwm_in  = '0;
               even_in = !even_ff;
            end else begin
               pwm_in = pwm_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      rd_addr = is_tick ? col_in : pcol_x[COL_W-1:0];
   end

   // stage 1: current column word, with forwarding of last cycle's write
   always_comb begin
      cur_word = fwd_hit ? fwd_word_ff : (col_valid_ff[s1_addr_ff] ? rd_data : '0);
      merged = cur_word;
      merged[s1_row_ff * ENTRY_W +: ENTRY_W] = s1_entry_ff;
      for (int r = 0; r < NUM_ROWS; r++) begin
         entry = cur_word[r * ENTRY_W +: ENTRY_W];
         lit   = s1_even_ff || entry[ENTRY_W-1];
         red_rows[r]   = lit && (entry[COLOR_BITS-1:0] > s1_pwm_ff);
         green_rows[r] = lit && (entry[2*COLOR_BITS-1:COLOR_BITS] > s1_pwm_ff);
         blue_rows[r]  = lit && (entry[3*COLOR_BITS-1:2*COLOR_BITS] > s1_pwm_ff);
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_tick_in   = s1_tick_ff;
      s1_we_in     = s1_we_ff;
      s1_addr_in   = s1_addr_ff;
      s1_row_in    = s1_row_ff;
      s1_entry_in  = s1_entry_ff;
      s1_status_in = s1_status_ff;
      s1_pwm_in    = s1_pwm_ff;
      s1_even_in   = s1_even_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_word_in  = fwd_word_ff;
      if (!s1_stall) begin
         s1_valid_in  = accept;
         s1_tick_in   = is_tick;
         s1_we_in     = in_range;
         s1_addr_in   = rd_addr;
         s1_row_in    = req_payload.pixel_row;
         s1_entry_in  = {req_payload.bright_flag, blue_x[COLOR_BITS-1:0],
                         green_x[COLOR_BITS-1:0], red_x[COLOR_BITS-1:0]};
         s1_status_in = req_payload.status_byte_in;
         s1_pwm_in    = pwm_in;
         s1_even_in   = even_in;
         fwd_valid_in = s1_write;
         fwd_addr_in  = s1_addr_ff;
         fwd_word_in  = merged;
      end
      col_valid_in = col_valid_ff;
      if (s1_write) begin
         col_valid_in[s1_addr_ff] = 1'b1;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      if (s1_valid_ff && s1_tick_ff && !s1_stall) begin
         out_valid_in           = 1'b1;
         out_in.active_column   = col_x[2:0];
         out_in.status_byte_out = s1_status_ff;
         out_in.red_rows        = red_rows;
         out_in.green_rows      = green_rows;
         out_in.blue_rows       = blue_rows;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         pwm_ff       <= '0;
         even_ff      <= 1'b1;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         col_valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         pwm_ff       <= pwm_in;
         even_ff      <= even_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         col_valid_ff <= col_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tick_ff   <= s1_tick_in;
      s1_we_ff     <= s1_we_in;
      s1_addr_ff   <= s1_addr_in;
      s1_row_ff    <= s1_row_in;
      s1_entry_ff  <= s1_entry_in;
      s1_status_ff <= s1_status_in;
      s1_pwm_ff    <= s1_pwm_in;
      s1_even_ff   <= s1_even_in;
      fwd_addr_ff  <= fwd_addr_in;
      fwd_word_ff  <= fwd_word_in;
      out_ff       <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

>>> rtl/rgbled_checker.sv
`include "rgb_led_matrix_scan_pwm_assert.svh"

module rgbled_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input rgbled_pkg::req_type req_payload,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input rgbled_pkg::rsp_type rsp_payload
);

   import rgbled_pkg::*;

   `RGBLED_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `RGBLED_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `RGBLED_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   `RGBLED_ASSERT_LATER2(a_tick_result, clock, reset, req_valid && !req_stall && (req_payload.func == FUNC_TICK) && !rsp_valid, rsp_valid)

endmodule

bind rgb_led_matrix_scan_pwm rgbled_checker u_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 100ps

class scan_scoreboard;
   localparam int COLUMNS   = rgbled_pkg::NUM_COLUMNS_DEF;
   localparam int ROWS      = rgbled_pkg::NUM_ROWS;
   localparam int LEVEL_TOP = (1 << rgbled_pkg::COLOR_BITS_DEF) - 1;

   logic [3:0] red_mem   [COLUMNS*ROWS];
   logic [3:0] green_mem [COLUMNS*ROWS];
   logic [3:0] blue_mem  [COLUMNS*ROWS];
   logic       bright_mem[COLUMNS*ROWS];
   int         column;
   int         pwm_cycle;
   logic       full_phase;

   rgbled_pkg::rsp_type lit_rows_q[$];
   int errors;

   function new();
      foreach (red_mem[i]) begin
         red_mem[i]    = '0;
         green_mem[i]  = '0;
         blue_mem[i]   = '0;
         bright_mem[i] = 1'b0;
      end
      column     = 0;
      pwm_cycle  = 0;
      full_phase = 1'b1;
      errors     = 0;
   endfunction

   function int pending();
      return lit_rows_q.size();
   endfunction

   function void flag(string msg);
      errors++;
      if (errors <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function void note_transfer(rgbled_pkg::req_type r);
      rgbled_pkg::rsp_type e;
      int slot;
      logic lit;
      if (r.func == rgbled_pkg::FUNC_WRITE) begin
         if (r.pixel_column < COLUMNS) begin
            slot = r.pixel_column * ROWS + r.pixel_row;
            red_mem[slot]    = r.red_level;
            green_mem[slot]  = r.green_level;
            blue_mem[slot]   = r.blue_level;
            bright_mem[slot] = r.bright_flag;
         end
         return;
      end
      column++;
      if (column >= COLUMNS) begin
         column = 0;
         pwm_cycle++;
         if (pwm_cycle > LEVEL_TOP) begin
            pwm_cycle  = 0;
            full_phase = ~full_phase;
         end
      end
      e.active_column   = column[2:0];
      e.status_byte_out = r.status_byte_in;
      for (int row = 0; row < ROWS; row++) begin
         slot = column * ROWS + row;
         lit  = full_phase || bright_mem[slot];
         e.red_rows[row]   = lit && (int'(red_mem[slot]) > pwm_cycle);
         e.green_rows[row] = lit && (int'(green_mem[slot]) > pwm_cycle);
         e.blue_rows[row]  = lit && (int'(blue_mem[slot]) > pwm_cycle);
      end
      lit_rows_q.push_back(e);
   endfunction

   function void check_rows(rgbled_pkg::rsp_type a);
      rgbled_pkg::rsp_type e;
      if (lit_rows_q.size() == 0) begin
         flag($sformatf("unexpected result: %h", a));
         return;
      end
      e = lit_rows_q.pop_front();
      if (a.active_column !== e.active_column)
         flag($sformatf("active_column: expected %0d, got %0d", e.active_column,
                        a.active_column));
      if (a.status_byte_out !== e.status_byte_out)
         flag($sformatf("status_byte_out: expected %h, got %h", e.status_byte_out,
                        a.status_byte_out));
      if (a.red_rows !== e.red_rows)
         flag($sformatf("red_rows col %0d: expected %b, got %b", e.active_column,
                        e.red_rows, a.red_rows));
      if (a.green_rows !== e.green_rows)
         flag($sformatf("green_rows col %0d: expected %b, got %b", e.active_column,
                        e.green_rows, a.green_rows));
      if (a.blue_rows !== e.blue_rows)
         flag($sformatf("blue_rows col %0d: expected %b, got %b", e.active_column,
                        e.blue_rows, a.blue_rows));
   endfunction

   function void close_out();
      while (lit_rows_q.size() != 0) begin
         flag($sformatf("missing result: expected %h", lit_rows_q.pop_front()));
      end
   endfunction
endclass

module tb_top;
   import rgbled_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 200000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   scan_scoreboard sb = new();
   bit send_burst;
   int cycle_count;

   rgb_led_matrix_scan_pwm dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial forever #5 clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   function automatic req_type pixel_write(int col, int row, int r, int g, int b, bit br);
      req_type p;
      p                = req_type'($bits(req_type)'($urandom));
      p.func           = FUNC_WRITE;
      p.pixel_column   = col[2:0];
      p.pixel_row      = row[2:0];
      p.red_level      = r[3:0];
      p.green_level    = g[3:0];
      p.blue_level     = b[3:0];
      p.bright_flag    = br;
      return p;
   endfunction

   function automatic req_type refresh_tick(int status);
      req_type p;
      p                = req_type'($bits(req_type)'($urandom));
      p.func           = FUNC_TICK;
      p.status_byte_in = status[7:0];
      return p;
   endfunction

   function automatic int pick_level();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom_range(0, 1) ? 15 : 0;
      end
      return $urandom_range(0, 15);
   endfunction

   task automatic send_item(req_type r);
      int gap;
      if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sb.note_transfer(r);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin : result_side
      int  hold;
      bit  rsp_burst;
      rsp_burst = 1'b0;
      forever begin
         if ($urandom_range(0, 40) == 0) rsp_burst = !rsp_burst;
         hold = rsp_burst ? 0 : $urandom_range(0, 7);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_rows(rsp_payload);
      end
   end

   initial begin : request_side
      req_type item;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first tick after reset lands on column 1, store still dark
      send_item(refresh_tick(8'hA5));
      send_item(pixel_write(2, 0, 15, 0, 15, 1'b1));
      send_item(pixel_write(2, 7, 0, 15, 1, 1'b0));
      send_item(pixel_write(0, 3, 15, 15, 15, 1'b0));
      send_item(pixel_write(7, 7, 15, 15, 15, 1'b1));
      send_item(pixel_write(7, 0, 1, 1, 1, 1'b0));
      send_item(pixel_write(1, 4, 0, 0, 0, 1'b1));
      send_item(refresh_tick(8'hFF));
      send_item(refresh_tick(8'h00));
      send_item(refresh_tick(8'h55));
      send_item(refresh_tick(8'hAA));
      send_item(refresh_tick(8'h01));
      send_item(refresh_tick(8'h80));
      // column wraps, PWM cycle moves to 1: level 1 goes dark
      send_item(refresh_tick(8'h7F));
      send_item(refresh_tick(8'hFE));
      send_item(pixel_write(2, 0, 2, 2, 2, 1'b0));
      send_item(refresh_tick(8'h3C));
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 400 == 200) drain_results();
         if ($urandom_range(0, 99) < 65) begin
            item = refresh_tick($urandom_range(0, 255));
         end else begin
            item = pixel_write($urandom_range(0, 7), $urandom_range(0, 7), pick_level(),
                               pick_level(), pick_level(), 1'($urandom_range(0, 1)));
         end
         send_item(item);
      end

      drain_results();
      repeat (10) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule

>>> rgb_led_matrix_scan_pwm.f
+incdir+rtl
rtl/rgbled_pkg.sv
rtl/rgbled_ram.sv
rtl/rgb_led_matrix_scan_pwm.sv
rtl/rgbled_checker.sv
bench/tb_top.sv
